[hw/rtl/brta_pkg.sv]
// ----------------------------------------------------------------------------
// brta_pkg
// Shared types, constants and codes for the boot region table allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package brta_pkg;

  localparam int TABLE_DEPTH = 128;
  localparam int ADDR_BITS   = 48;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int ENTRY_W     = 2 * ADDR_BITS;
  localparam int COUNT_OUT_W = 8;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [IDX_W-1:0]     idx_t;
  typedef logic [CNT_W-1:0]     cnt_t;

  localparam addr_t ADDR_MAX    = '1;
  localparam addr_t FLOOR_RESET = addr_t'(4096);

  localparam logic [2:0] OP_ADD_MEM    = 3'd0;
  localparam logic [2:0] OP_REMOVE_MEM = 3'd1;
  localparam logic [2:0] OP_RESERVE    = 3'd2;
  localparam logic [2:0] OP_FREE       = 3'd3;
  localparam logic [2:0] OP_ALLOC      = 3'd4;
  localparam logic [2:0] OP_TRIM       = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_SPACE = 2'd1;
  localparam logic [1:0] ST_NO_FIT   = 2'd2;

  localparam logic CFG_ALLOC_LIMIT = 1'b0;
  localparam logic CFG_LOW_FLOOR   = 1'b1;

  typedef struct packed {
    logic  en;
    idx_t  addr;
    addr_t start;
    addr_t len;
  } bank_wr_t;

  typedef struct packed {
    logic  en;
    cnt_t  used;
    addr_t sum;
  } bank_commit_t;

  typedef enum logic [4:0] {
    S_IDLE,
    S_RNG1,
    S_RNG2,
    S_W_RD,
    S_W_WAIT,
    S_W_EVAL,
    S_W_TRIM,
    S_W_EM1,
    S_W_EM2,
    S_FIN,
    S_A_INIT,
    S_A_TRY,
    S_A_TRY2,
    S_G_MI,
    S_G_MW,
    S_G_RJ,
    S_G_RW,
    S_G_RE,
    S_G_END,
    S_P_CLAMP,
    S_P_ROUND,
    S_P_DIFF,
    S_P_FIT,
    S_A_POST,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[hw/rtl/boot_region_table_allocator.sv]
// ----------------------------------------------------------------------------
// boot_region_table_allocator
// Sorted memory/reserved interval tables with add, remove, allocate and trim.
// ----------------------------------------------------------------------------
// Add/remove/reserve/free/trim: one RAM read, evaluate and up to two writes
//   per table entry.
// Allocate: walks memory entries and the reserved entries against them, tries
//   candidate gaps, then one reserve pass; a retry repeats the search.
// One request at a time; busy stays high until done pulses for one cycle.
// Reset: synchronous, empties both tables at once; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module boot_region_table_allocator
  import brta_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [2:0]             op,
  input  wire addr_t                  base,
  input  wire addr_t                  len,
  input  wire logic [5:0]             align_log2,
  input  wire addr_t                  min_addr,
  input  wire addr_t                  max_addr,
  input  wire logic                   cfg_wr,
  input  wire logic                   cfg_addr,
  input  wire addr_t                  cfg_data,
  output logic                        done,
  output logic [1:0]                  status,
  output addr_t                       alloc_addr,
  output addr_t                       memory_total,
  output addr_t                       reserved_total,
  output logic [COUNT_OUT_W-1:0]      memory_count,
  output logic [COUNT_OUT_W-1:0]      reserved_count
);

  state_t state, state_next;

  addr_t alloc_limit, low_floor;

  logic [2:0] op_q;
  addr_t b_q, e_q, len_q, am1_q, minv_q, maxv_q, minv_cur;
  addr_t hi_q, lo_q, hi_eff, m_q;
  cnt_t  i_q, j_q, jstart_q, jfirst_q, n_q;
  logic  seen_q, ovf_q, placed_q, last_q, tgt_rsv, alloc_ctx;
  addr_t acc_q, rs_q, ln_q, re_q;
  logic  em1_v, em2_v;
  addr_t em1_s, em1_l, em2_s, em2_l;
  addr_t s2_q, e2_q;
  logic  ok_q;
  addr_t p_q, me_q, ps_q, pe_q, cs_q, ce_q, cand_q, diff_q;
  logic  piece_inner, fit1_q, retry_q;
  addr_t addr_q, res_addr_q;
  logic [1:0] status_q, try_st;

  // bank wiring
  addr_t mem_rd_start, mem_rd_len, rsv_rd_start, rsv_rd_len;
  cnt_t  mem_used, rsv_used;
  addr_t mem_sum, rsv_sum;
  bank_wr_t     mem_wr, rsv_wr;
  bank_commit_t mem_cm, rsv_cm;
  idx_t  mem_rd_addr, rsv_rd_addr;

  logic  walk_add, walk_trim, w_more, g_inner, emit_v, wr_ok;
  cnt_t  used_tgt;
  addr_t emit_s, emit_l, rd_s, rd_l;
  logic [ADDR_BITS:0] diff_w;

  brta_bank u_mem (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (mem_rd_addr),
    .rd_start (mem_rd_start),
    .rd_len   (mem_rd_len),
    .wr       (mem_wr),
    .commit   (mem_cm),
    .used     (mem_used),
    .sum      (mem_sum)
  );

  brta_bank u_rsv (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rsv_rd_addr),
    .rd_start (rsv_rd_start),
    .rd_len   (rsv_rd_len),
    .wr       (rsv_wr),
    .commit   (rsv_cm),
    .used     (rsv_used),
    .sum      (rsv_sum)
  );

  assign walk_add  = alloc_ctx || op_q == OP_ADD_MEM || op_q == OP_RESERVE;
  assign walk_trim = !alloc_ctx && op_q == OP_TRIM;
  assign used_tgt  = tgt_rsv ? rsv_used : mem_used;
  assign w_more    = i_q < used_tgt;
  assign g_inner   = (j_q < rsv_used) && (p_q < me_q);
  assign rd_s      = tgt_rsv ? rsv_rd_start : mem_rd_start;
  assign rd_l      = tgt_rsv ? rsv_rd_len : mem_rd_len;

  assign mem_rd_addr = i_q[IDX_W-1:0];
  assign rsv_rd_addr = (state == S_G_RJ) ? j_q[IDX_W-1:0] : i_q[IDX_W-1:0];

  assign emit_v = (state == S_W_EM1) ? em1_v : ((state == S_W_EM2) ? em2_v : 1'b0);
  assign emit_s = (state == S_W_EM1) ? em1_s : em2_s;
  assign emit_l = (state == S_W_EM1) ? em1_l : em2_l;
  assign wr_ok  = n_q != cnt_t'(TABLE_DEPTH);

  assign diff_w = {1'b0, ce_q} - {1'b0, cand_q};

  always_comb begin
    mem_wr.en    = emit_v && wr_ok && !tgt_rsv;
    mem_wr.addr  = n_q[IDX_W-1:0];
    mem_wr.start = emit_s;
    mem_wr.len   = emit_l;
    rsv_wr.en    = emit_v && wr_ok && tgt_rsv;
    rsv_wr.addr  = n_q[IDX_W-1:0];
    rsv_wr.start = emit_s;
    rsv_wr.len   = emit_l;
    mem_cm.en    = (state == S_FIN) && !ovf_q && !tgt_rsv;
    mem_cm.used  = n_q;
    mem_cm.sum   = acc_q;
    rsv_cm.en    = (state == S_FIN) && !ovf_q && tgt_rsv;
    rsv_cm.used  = n_q;
    rsv_cm.sum   = acc_q;
  end

  assign busy           = state != S_IDLE;
  assign done           = state == S_DONE;
  assign status         = status_q;
  assign alloc_addr     = res_addr_q;
  assign memory_total   = mem_sum;
  assign reserved_total = rsv_sum;
  assign memory_count   = COUNT_OUT_W'(mem_used);
  assign reserved_count = COUNT_OUT_W'(rsv_used);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      alloc_limit <= ADDR_MAX;
      low_floor   <= FLOOR_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_addr)
        CFG_ALLOC_LIMIT: alloc_limit <= cfg_data;
        CFG_LOW_FLOOR:   low_floor   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          case (op)
            OP_ADD_MEM, OP_REMOVE_MEM, OP_RESERVE, OP_FREE: state_next = S_RNG1;
            OP_ALLOC: state_next = S_A_INIT;
            OP_TRIM:  state_next = S_W_RD;
            default:  state_next = S_DONE;
          endcase
        end
      end
      S_RNG1: state_next = S_RNG2;
      S_RNG2: state_next = (m_q == '0) ? S_DONE : S_W_RD;
      S_W_RD: begin
        if (w_more) begin
          state_next = S_W_WAIT;
        end else if (walk_add && !placed_q) begin
          state_next = S_W_EM1;
        end else begin
          state_next = S_FIN;
        end
      end
      S_W_WAIT: state_next = S_W_EVAL;
      S_W_EVAL: state_next = walk_trim ? S_W_TRIM : S_W_EM1;
      S_W_TRIM: state_next = S_W_EM1;
      S_W_EM1:  state_next = S_W_EM2;
      S_W_EM2:  state_next = last_q ? S_FIN : S_W_RD;
      S_FIN:    state_next = alloc_ctx ? S_A_POST : S_DONE;
      S_A_INIT: state_next = S_A_TRY;
      S_A_TRY:  state_next = S_A_TRY2;
      S_A_TRY2: state_next = (len_q == '0) ? S_A_POST : S_G_MI;
      S_G_MI:   state_next = (i_q < mem_used) ? S_G_MW : S_A_POST;
      S_G_MW:   state_next = S_G_RJ;
      S_G_RJ:   state_next = g_inner ? S_G_RW : S_G_END;
      S_G_RW:   state_next = S_G_RE;
      S_G_RE: begin
        if (re_q <= p_q) begin
          state_next = S_G_RJ;
        end else if (rs_q >= me_q) begin
          state_next = S_G_END;
        end else if (rs_q > p_q) begin
          state_next = S_P_CLAMP;
        end else begin
          state_next = S_G_RJ;
        end
      end
      S_G_END:   state_next = (p_q < me_q) ? S_P_CLAMP : S_G_MI;
      S_P_CLAMP: state_next = S_P_ROUND;
      S_P_ROUND: state_next = S_P_DIFF;
      S_P_DIFF:  state_next = S_P_FIT;
      S_P_FIT: begin
        if (fit1_q && diff_q >= len_q) begin
          state_next = S_RNG1;
        end else if (piece_inner) begin
          state_next = S_G_RJ;
        end else begin
          state_next = S_G_MI;
        end
      end
      S_A_POST: begin
        if (try_st != ST_OK && !retry_q && minv_q != '0) begin
          state_next = S_A_TRY;
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op_q       <= op;
        b_q        <= base;
        len_q      <= len;
        am1_q      <= ~(ADDR_MAX << align_log2);
        minv_q     <= min_addr;
        maxv_q     <= max_addr;
        minv_cur   <= min_addr;
        i_q        <= '0;
        n_q        <= '0;
        acc_q      <= '0;
        ovf_q      <= 1'b0;
        placed_q   <= 1'b0;
        last_q     <= 1'b0;
        retry_q    <= 1'b0;
        alloc_ctx  <= 1'b0;
        tgt_rsv    <= (op == OP_RESERVE) || (op == OP_FREE);
        status_q   <= ST_OK;
        res_addr_q <= '0;
      end
      S_RNG1: begin
        m_q <= (len_q < ~b_q) ? len_q : ~b_q;
      end
      S_RNG2: begin
        e_q      <= b_q + m_q;
        i_q      <= '0;
        n_q      <= '0;
        acc_q    <= '0;
        ovf_q    <= 1'b0;
        placed_q <= 1'b0;
        last_q   <= 1'b0;
      end
      S_W_RD: begin
        if (!w_more) begin
          // range not merged anywhere: append it at the end
          em1_v  <= 1'b1;
          em1_s  <= b_q;
          em1_l  <= e_q - b_q;
          em2_v  <= 1'b0;
          last_q <= 1'b1;
        end
      end
      S_W_WAIT: begin
        rs_q <= rd_s;
        ln_q <= rd_l;
        re_q <= rd_s + rd_l;
      end
      S_W_EVAL: begin
        if (walk_trim) begin
          ok_q <= ((rs_q & am1_q) == '0) || ((rs_q | am1_q) != ADDR_MAX);
          s2_q <= ((rs_q & am1_q) == '0) ? rs_q : (rs_q | am1_q) + 1'b1;
          e2_q <= re_q & ~am1_q;
        end else if (walk_add) begin
          if (re_q < b_q) begin
            em1_v <= 1'b1;
            em1_s <= rs_q;
            em1_l <= ln_q;
            em2_v <= 1'b0;
          end else if (rs_q > e_q) begin
            placed_q <= 1'b1;
            em2_s    <= rs_q;
            em2_l    <= ln_q;
            em1_v    <= 1'b1;
            if (!placed_q) begin
              em1_s <= b_q;
              em1_l <= e_q - b_q;
              em2_v <= 1'b1;
            end else begin
              em1_s <= rs_q;
              em1_l <= ln_q;
              em2_v <= 1'b0;
            end
          end else begin
            em1_v <= 1'b0;
            em2_v <= 1'b0;
            if (rs_q < b_q) b_q <= rs_q;
            if (re_q > e_q) e_q <= re_q;
          end
        end else begin
          if (re_q <= b_q || rs_q >= e_q) begin
            em1_v <= 1'b1;
            em1_s <= rs_q;
            em1_l <= ln_q;
            em2_v <= 1'b0;
          end else begin
            em1_v <= rs_q < b_q;
            em1_s <= rs_q;
            em1_l <= b_q - rs_q;
            em2_v <= re_q > e_q;
            em2_s <= e_q;
            em2_l <= re_q - e_q;
          end
        end
      end
      S_W_TRIM: begin
        em1_v <= ok_q && (s2_q < e2_q);
        em1_s <= s2_q;
        em1_l <= e2_q - s2_q;
        em2_v <= 1'b0;
      end
      S_W_EM1, S_W_EM2: begin
        if (emit_v) begin
          if (wr_ok) begin
            n_q   <= n_q + 1'b1;
            acc_q <= acc_q + emit_l;
          end else begin
            ovf_q <= 1'b1;
          end
        end
        if (state == S_W_EM2) begin
          i_q <= i_q + 1'b1;
        end
      end
      S_FIN: begin
        if (alloc_ctx) begin
          try_st <= ovf_q ? ST_NO_SPACE : ST_OK;
        end else begin
          status_q <= ovf_q ? ST_NO_SPACE : ST_OK;
        end
      end
      S_A_INIT: begin
        hi_q      <= (maxv_q == '0 || maxv_q > alloc_limit) ? alloc_limit : maxv_q;
        alloc_ctx <= 1'b1;
        tgt_rsv   <= 1'b1;
      end
      S_A_TRY: begin
        lo_q <= (minv_cur > low_floor) ? minv_cur : low_floor;
      end
      S_A_TRY2: begin
        hi_eff   <= (hi_q < lo_q) ? lo_q : hi_q;
        i_q      <= '0;
        jstart_q <= '0;
        try_st   <= ST_NO_FIT;
      end
      S_G_MI: begin
        try_st <= ST_NO_FIT;
      end
      S_G_MW: begin
        p_q    <= mem_rd_start;
        me_q   <= mem_rd_start + mem_rd_len;
        j_q    <= jstart_q;
        seen_q <= 1'b0;
      end
      S_G_RW: begin
        rs_q <= rsv_rd_start;
        re_q <= rsv_rd_start + rsv_rd_len;
      end
      S_G_RE: begin
        if (re_q <= p_q) begin
          j_q <= j_q + 1'b1;
        end else begin
          if (!seen_q) begin
            seen_q   <= 1'b1;
            jfirst_q <= j_q;
          end
          if (rs_q >= me_q) begin
            // break: handled in S_G_END
          end else if (rs_q > p_q) begin
            ps_q        <= p_q;
            pe_q        <= rs_q;
            piece_inner <= 1'b1;
          end else begin
            p_q <= re_q;
            j_q <= j_q + 1'b1;
          end
        end
      end
      S_G_END: begin
        // reserved entries skipped here stay below every later memory entry
        jstart_q <= seen_q ? jfirst_q : j_q;
        if (p_q < me_q) begin
          ps_q        <= p_q;
          pe_q        <= me_q;
          piece_inner <= 1'b0;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      S_P_CLAMP: begin
        cs_q <= (ps_q < lo_q) ? lo_q : ((ps_q > hi_eff) ? hi_eff : ps_q);
        ce_q <= (pe_q < lo_q) ? lo_q : ((pe_q > hi_eff) ? hi_eff : pe_q);
      end
      S_P_ROUND: begin
        ok_q   <= ((cs_q & am1_q) == '0) || ((cs_q | am1_q) != ADDR_MAX);
        cand_q <= ((cs_q & am1_q) == '0) ? cs_q : (cs_q | am1_q) + 1'b1;
      end
      S_P_DIFF: begin
        diff_q <= diff_w[ADDR_BITS-1:0];
        fit1_q <= ok_q && !diff_w[ADDR_BITS] && (diff_w[ADDR_BITS-1:0] != '0);
      end
      S_P_FIT: begin
        if (fit1_q && diff_q >= len_q) begin
          addr_q <= cand_q;
          b_q    <= cand_q;
        end else if (piece_inner) begin
          p_q <= re_q;
          j_q <= j_q + 1'b1;
        end else begin
          i_q <= i_q + 1'b1;
        end
      end
      S_A_POST: begin
        if (try_st == ST_OK) begin
          status_q   <= ST_OK;
          res_addr_q <= addr_q;
        end else if (!retry_q && minv_q != '0) begin
          retry_q  <= 1'b1;
          minv_cur <= '0;
        end else begin
          status_q   <= try_st;
          res_addr_q <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

[hw/rtl/brta_ram.sv]
// ----------------------------------------------------------------------------
// brta_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[hw/rtl/brta_bank.sv]
// ----------------------------------------------------------------------------
// brta_bank
// One interval table: two RAMs used ping-pong. Reads hit the live copy,
// rebuilt entries go to the spare copy, commit swaps them.
// ----------------------------------------------------------------------------
`default_nettype none

module brta_bank
  import brta_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire idx_t         rd_addr,
  output addr_t             rd_start,
  output addr_t             rd_len,
  input  wire bank_wr_t     wr,
  input  wire bank_commit_t commit,
  output cnt_t              used,
  output addr_t             sum
);

  logic                 sel;
  logic                 rd_sel;
  logic [ENTRY_W-1:0]   rdata0;
  logic [ENTRY_W-1:0]   rdata1;
  logic [ENTRY_W-1:0]   rdata;

  brta_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram0 (
    .clk   (clk),
    .we    (wr.en && sel),
    .waddr (wr.addr),
    .wdata ({wr.start, wr.len}),
    .raddr (rd_addr),
    .rdata (rdata0)
  );

  brta_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram1 (
    .clk   (clk),
    .we    (wr.en && !sel),
    .waddr (wr.addr),
    .wdata ({wr.start, wr.len}),
    .raddr (rd_addr),
    .rdata (rdata1)
  );

  assign rdata    = rd_sel ? rdata1 : rdata0;
  assign rd_start = rdata[ENTRY_W-1:ADDR_BITS];
  assign rd_len   = rdata[ADDR_BITS-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      sel    <= 1'b0;
      rd_sel <= 1'b0;
      used   <= '0;
      sum    <= '0;
    end else begin
      rd_sel <= sel;
      if (commit.en) begin
        sel  <= !sel;
        used <= commit.used;
        sum  <= commit.sum;
      end
    end
  end

endmodule

`default_nettype wire
